### hdl/hfi_pkg.sv
// ----------------------------------------------------------------------------
// Hemisphere flux integrator package
// Shared types, codes and fixed-point constants of the flux integrator.
// ----------------------------------------------------------------------------
package hfi_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS   = 8'd1;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  // Serial arithmetic unit widths.
  localparam int MUL_A_W = 85;
  localparam int MUL_B_W = 35;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 101;
  localparam int DIV_D_W = 16;
  localparam int STEP_W  = 7;

  localparam logic [63:0]  PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [127:0] PI_SQ  = {64'd0, PI_Q60} * {64'd0, PI_Q60};
  // pi^2/2 in Q32.
  localparam logic [MUL_B_W-1:0] HALF_PI_SQ = PI_SQ[MUL_B_W+88:89];

  typedef struct packed {
    logic        kind;
    logic [7:0]  parallel_index;
    logic [15:0] radial_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] flux;
    logic        empty_parallel;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic mul_start;
    logic div_start;
  } md_req_t;

  typedef struct packed {
    logic done;
  } md_rsp_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT_WR,
    ST_RD,
    ST_DIV,
    ST_SCALE,
    ST_M_SINE,
    ST_M_H,
    ST_M_R1,
    ST_M_R2,
    ST_DIV_B,
    ST_EMIT
  } st_e;

endpackage

### hdl/hfi_chan_if.sv
// ----------------------------------------------------------------------------
// Flux integrator channel
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface hfi_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/hfi_muldiv.sv
// ----------------------------------------------------------------------------
// Flux integrator serial multiplier and divider
// Shift-add multiplier and restoring divider, one bit per cycle, shared.
// ----------------------------------------------------------------------------
module hfi_muldiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hfi_pkg::md_req_t              req_i,
  input  logic [hfi_pkg::MUL_A_W-1:0]   mul_a_i,
  input  logic [hfi_pkg::MUL_B_W-1:0]   mul_b_i,
  input  logic [hfi_pkg::DIV_N_W-1:0]   div_n_i,
  input  logic [hfi_pkg::DIV_D_W-1:0]   div_d_i,
  output hfi_pkg::md_rsp_t              rsp_o,
  output logic [hfi_pkg::MUL_P_W-1:0]   prod_o,
  output logic [hfi_pkg::DIV_N_W-1:0]   quot_o
);

  localparam int AW = hfi_pkg::MUL_A_W;
  localparam int BW = hfi_pkg::MUL_B_W;
  localparam int PW = hfi_pkg::MUL_P_W;
  localparam int NW = hfi_pkg::DIV_N_W;
  localparam int DW = hfi_pkg::DIV_D_W;
  localparam int SW = hfi_pkg::STEP_W;

  hfi_pkg::md_op_e op_q, op_d;
  logic [SW-1:0] step_q, step_d;
  logic          done_q, done_d;
  logic [AW-1:0] a_q, a_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsr_q, dsr_d;

  logic [AW:0]   mul_sum;
  logic [DW:0]   div_trial;
  logic          div_ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= hfi_pkg::MD_IDLE;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      op_q   <= op_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  always_comb begin
    op_d   = op_q;
    step_d = step_q;
    done_d = 1'b0;
    a_d    = a_q;
    prod_d = prod_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;

    mul_sum   = {1'b0, prod_q[PW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);
    div_trial = {rem_q, quo_q[NW-1]};
    div_ge    = (div_trial >= {1'b0, dsr_q});

    unique case (op_q)
      hfi_pkg::MD_IDLE: begin
        if (req_i.mul_start) begin
          op_d   = hfi_pkg::MD_MUL;
          step_d = SW'(BW - 1);
          a_d    = mul_a_i;
          prod_d = {{AW{1'b0}}, mul_b_i};
        end else if (req_i.div_start) begin
          op_d   = hfi_pkg::MD_DIV;
          step_d = SW'(NW - 1);
          quo_d  = div_n_i;
          rem_d  = '0;
          dsr_d  = div_d_i;
        end
      end
      hfi_pkg::MD_MUL: begin
        prod_d = {mul_sum, prod_q[BW-1:1]};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          op_d   = hfi_pkg::MD_IDLE;
          done_d = 1'b1;
        end
      end
      hfi_pkg::MD_DIV: begin
        // The partial remainder stays below the divisor, so it fits DW bits.
        rem_d  = div_ge ? DW'(div_trial - {1'b0, dsr_q}) : div_trial[DW-1:0];
        quo_d  = {quo_q[NW-2:0], div_ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          op_d   = hfi_pkg::MD_IDLE;
          done_d = 1'b1;
        end
      end
      default: op_d = hfi_pkg::MD_IDLE;
    endcase
  end

  assign rsp_o.done = done_q;
  assign prod_o     = prod_q;
  assign quot_o     = quo_q;

endmodule

### hdl/hemisphere_flux_integrator_unit.sv
// ----------------------------------------------------------------------------
// Hemisphere flux integrator
// Bins intensity points per parallel and integrates flux over the hemisphere.
// ----------------------------------------------------------------------------
// Points are summed and counted per parallel in a bin memory with a registered
// read, so each point beat takes a read and then a write back.
// A point for a parallel above BANDS is dropped in its accept cycle. A compute
// beat walks the bins in order, clearing each as it is read, and runs every
// average, scale, sine weight and radius product through one shared bit-serial
// multiplier and divider. The division of each band term by BANDS^2 is a
// reciprocal-multiply loop that retires four quotient bits per cycle. The time
// a compute beat takes is set by the 35-step multiplier, the 101-step divider
// and the 25-step band division; an empty parallel skips the divider. Bins
// hold zero after reset through per-bin valid bits. A finished result waits in
// an output register while new points are taken.
module hemisphere_flux_integrator_unit #(
  parameter int BANDS                   = 18,
  parameter int MAX_POINTS_PER_PARALLEL = 4095
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hfi_chan_if.sink   in_i,
  hfi_chan_if.source out_o,
  hfi_chan_if.sink   cfg_i
);

  localparam int NBINS = BANDS + 1;
  localparam int IDX_W = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS_PER_PARALLEL + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam int MEM_W = SUM_W + CNT_W;
  localparam int BSQ   = BANDS * BANDS;

  localparam int AW = hfi_pkg::MUL_A_W;
  localparam int BW = hfi_pkg::MUL_B_W;
  localparam int PW = hfi_pkg::MUL_P_W;
  localparam int NW = hfi_pkg::DIV_N_W;
  localparam int DW = hfi_pkg::DIV_D_W;

  // Band division by BANDS^2: four quotient bits per step over a dividend that
  // stays below 2^100. The reciprocal is exact for every partial dividend.
  localparam int BCH    = 4;
  localparam int BSTEPS = 25;
  localparam int BRK    = 2 * DW + BCH;
  localparam int BRW    = BRK + 1;
  localparam int BXW    = DW + BCH;
  localparam int BPW    = BXW + BRW;
  localparam logic [BRW-1:0] BRECIP =
    BRW'(((64'd1 << BRK) + 64'(BSQ) - 64'd1) / 64'(BSQ));

  // Q1.15 sine of parallel i, Taylor series in Q30 to the x^13 term.
  function automatic logic [16:0] sine_q15(int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] s15;
    x    = ((hfi_pkg::PI_Q60 >> 31) * 64'(i)) / 64'(BANDS);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + term;
    s15  = (acc + 64'd16384) >> 15;
    return (s15 > 64'd32768) ? 17'd32768 : s15[16:0];
  endfunction

  logic [16:0] sine_rom [NBINS];

  for (genvar g = 0; g < NBINS; g++) begin : g_sine
    assign sine_rom[g] = sine_q15(g);
  end

  // Bin memory and valid bits.
  logic [MEM_W-1:0] bin_mem [NBINS];
  logic [MEM_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [NBINS-1:0] vld_q;

  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  logic [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0] rd_cnt;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= bin_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[mem_raddr];
      end
    end
  end

  assign rd_sum = rd_vld_q ? rd_data_q[MEM_W-1:CNT_W] : '0;
  assign rd_cnt = rd_vld_q ? rd_data_q[CNT_W-1:0] : '0;

  // Configuration registers.
  logic [31:0] scale_q;
  logic [31:0] radius_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 32'd65536;
      radius_q <= 32'd65536;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.index == hfi_pkg::REG_INTENSITY_SCALE) begin
        scale_q <= cfg_i.data.value;
      end
      if (cfg_i.data.index == hfi_pkg::REG_SPHERE_RADIUS) begin
        radius_q <= cfg_i.data.value;
      end
    end
  end

  // Shared serial arithmetic.
  hfi_pkg::md_req_t md_req;
  hfi_pkg::md_rsp_t md_rsp;
  logic [AW-1:0]    mul_a;
  logic [BW-1:0]    mul_b;
  logic [NW-1:0]    div_n;
  logic [DW-1:0]    div_d;
  logic [PW-1:0]    prod;
  logic [NW-1:0]    quot;

  hfi_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (md_req),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .div_n_i (div_n),
    .div_d_i (div_d),
    .rsp_o   (md_rsp),
    .prod_o  (prod),
    .quot_o  (quot)
  );

  // Sequencer.
  hfi_pkg::st_e       state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [15:0]        val_q, val_d;
  logic [47:0]        a_prev_q, a_prev_d;
  logic [47:0]        a_cur_q, a_cur_d;
  logic [63:0]        flux_q, flux_d;
  logic               empty_q, empty_d;
  logic               sat_q, sat_d;
  logic               ovf_q, ovf_d;
  hfi_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [NW-1:0]      bq_q, bq_d;
  logic [DW-1:0]      br_q, br_d;
  logic [4:0]         bstep_q, bstep_d;

  logic [IDX_W-1:0]   idx_prev;
  logic [17:0]        sine_sum;
  logic [47:0]        a_new;
  logic [64:0]        flux_add;
  logic [BXW-1:0]     bx;
  logic [BPW-1:0]     bprod;
  logic [BCH-1:0]     bdig;
  logic [BXW-1:0]     bsub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hfi_pkg::ST_IDLE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    val_q    <= val_d;
    a_prev_q <= a_prev_d;
    a_cur_q  <= a_cur_d;
    flux_q   <= flux_d;
    empty_q  <= empty_d;
    sat_q    <= sat_d;
    out_q    <= out_d;
    bq_q     <= bq_d;
    br_q     <= br_d;
    bstep_q  <= bstep_d;
  end

  assign idx_prev = idx_q - 1'b1;
  assign sine_sum = {1'b0, sine_rom[idx_prev]} + {1'b0, sine_rom[idx_q]};
  assign a_new    = prod[63:16];
  assign flux_add = {1'b0, flux_q} + {1'b0, bq_q[70:7]};

  // One digit of the band division: the running remainder joined with the
  // next four dividend bits, divided through the reciprocal.
  assign bx    = {br_q, bq_q[NW-2 -: BCH]};
  assign bprod = BPW'(bx) * BPW'(BRECIP);
  assign bdig  = bprod[BRK+BCH-1:BRK];
  assign bsub  = bx - (BXW'(bdig) * BXW'(BSQ));

  assign in_i.ready  = (state_q == hfi_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    val_d       = val_q;
    a_prev_d    = a_prev_q;
    a_cur_d     = a_cur_q;
    flux_d      = flux_q;
    empty_d     = empty_q;
    sat_d       = sat_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    bq_d        = bq_q;
    br_d        = br_q;
    bstep_d     = bstep_q;

    mem_re    = 1'b0;
    mem_raddr = idx_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;

    md_req = '0;
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = '0;

    unique case (state_q)
      hfi_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.data.kind == hfi_pkg::KIND_COMPUTE) begin
            idx_d     = '0;
            flux_d    = '0;
            empty_d   = 1'b0;
            sat_d     = ovf_q;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_d   = hfi_pkg::ST_RD;
          end else if (in_i.data.parallel_index <= 8'(BANDS)) begin
            idx_d     = in_i.data.parallel_index[IDX_W-1:0];
            val_d     = in_i.data.radial_value;
            mem_re    = 1'b1;
            mem_raddr = in_i.data.parallel_index[IDX_W-1:0];
            state_d   = hfi_pkg::ST_PT_WR;
          end
        end
      end
      hfi_pkg::ST_PT_WR: begin
        if (rd_cnt >= CNT_W'(MAX_POINTS_PER_PARALLEL)) begin
          ovf_d = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {SUM_W'(rd_sum + SUM_W'(val_q)), CNT_W'(rd_cnt + 1'b1)};
        end
        state_d = hfi_pkg::ST_IDLE;
      end
      hfi_pkg::ST_RD: begin
        // The bin is cleared as it is consumed.
        mem_we = 1'b1;
        if (rd_cnt == '0) begin
          empty_d          = 1'b1;
          md_req.mul_start = 1'b1;
          mul_a            = '0;
          mul_b            = BW'(scale_q);
          state_d          = hfi_pkg::ST_SCALE;
        end else begin
          md_req.div_start = 1'b1;
          div_n            = NW'({rd_sum, 16'd0});
          div_d            = DW'(rd_cnt);
          state_d          = hfi_pkg::ST_DIV;
        end
      end
      hfi_pkg::ST_DIV: begin
        if (md_rsp.done) begin
          // An average never exceeds 16 integer bits, so 32 bits hold it.
          md_req.mul_start = 1'b1;
          mul_a            = AW'(quot[31:0]);
          mul_b            = BW'(scale_q);
          state_d          = hfi_pkg::ST_SCALE;
        end
      end
      hfi_pkg::ST_SCALE: begin
        if (md_rsp.done) begin
          if (idx_q == '0) begin
            a_prev_d  = a_new;
            idx_d     = idx_q + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_q + 1'b1;
            state_d   = hfi_pkg::ST_RD;
          end else begin
            a_cur_d          = a_new;
            md_req.mul_start = 1'b1;
            mul_a            = AW'({1'b0, a_prev_q} + {1'b0, a_new});
            mul_b            = BW'(sine_sum);
            state_d          = hfi_pkg::ST_M_SINE;
          end
        end
      end
      hfi_pkg::ST_M_SINE: begin
        if (md_rsp.done) begin
          md_req.mul_start = 1'b1;
          mul_a            = AW'(prod[65:0]);
          mul_b            = hfi_pkg::HALF_PI_SQ;
          state_d          = hfi_pkg::ST_M_H;
        end
      end
      hfi_pkg::ST_M_H: begin
        if (md_rsp.done) begin
          md_req.mul_start = 1'b1;
          mul_a            = AW'(prod[100:32]);
          mul_b            = BW'(radius_q);
          state_d          = hfi_pkg::ST_M_R1;
        end
      end
      hfi_pkg::ST_M_R1: begin
        if (md_rsp.done) begin
          md_req.mul_start = 1'b1;
          mul_a            = prod[100:16];
          mul_b            = BW'(radius_q);
          state_d          = hfi_pkg::ST_M_R2;
        end
      end
      hfi_pkg::ST_M_R2: begin
        if (md_rsp.done) begin
          bq_d    = prod[116:16];
          br_d    = '0;
          bstep_d = 5'(BSTEPS);
          state_d = hfi_pkg::ST_DIV_B;
        end
      end
      hfi_pkg::ST_DIV_B: begin
        if (bstep_q != '0) begin
          bq_d    = {1'b0, bq_q[NW-2-BCH:0], bdig};
          br_d    = bsub[DW-1:0];
          bstep_d = bstep_q - 1'b1;
        end else begin
          // Band term is the quotient shifted down by seven bits.
          if ((bq_q[NW-1:71] != '0) || flux_add[64]) begin
            flux_d = '1;
            sat_d  = 1'b1;
          end else begin
            flux_d = flux_add[63:0];
          end
          a_prev_d = a_cur_q;
          if (idx_q == IDX_W'(BANDS)) begin
            state_d = hfi_pkg::ST_EMIT;
          end else begin
            idx_d     = idx_q + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_q + 1'b1;
            state_d   = hfi_pkg::ST_RD;
          end
        end
      end
      hfi_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.flux           = flux_q;
          out_d.empty_parallel = empty_q;
          out_d.saturated      = sat_q;
          out_valid_d          = 1'b1;
          ovf_d                = 1'b0;
          state_d              = hfi_pkg::ST_IDLE;
        end
      end
      default: state_d = hfi_pkg::ST_IDLE;
    endcase
  end

endmodule
